// File: rtl/lspe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspe_pkg
// Shared widths, constants, register map and types of the line sensor
// position estimator.
// ----------------------------------------------------------------------------
package lspe_pkg;

    localparam int CHANNELS_DEFAULT = 8;

    localparam int SENSOR_W = 8;
    localparam int POS_W    = 8;
    localparam int COUNT_W  = 4;
    localparam int ALPHA_W  = 9;
    localparam int SMOOTH_W = 24;
    localparam int FRAC_W   = 16;
    localparam int ALPHA_FRAC_W = 8;

    localparam int POS_SPAN  = 160;
    localparam int POS_RESET = 80;

    localparam logic [ALPHA_W-1:0]  ALPHA_ONE    = ALPHA_W'(256);
    localparam logic [SMOOTH_W-1:0] SMOOTH_RESET = SMOOTH_W'(POS_RESET << FRAC_W);
    localparam logic [POS_W-1:0]    HELD_RESET   = POS_W'(POS_RESET);

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_INVERT  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ALPHA   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_POS_MIN = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_POS_MAX = 2'd3;

    typedef struct packed {
        logic               invert_logic;
        logic [ALPHA_W-1:0] filter_alpha;
        logic [POS_W-1:0]   pos_min;
        logic [POS_W-1:0]   pos_max;
    } cfg_t;

endpackage

// File: rtl/lspe_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspe_in_if
// Frame channel: one detector bitmap per transfer.
// ----------------------------------------------------------------------------
interface lspe_in_if import lspe_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [SENSOR_W-1:0] sensor_bits;

    modport source (output valid, output sensor_bits, input ready);
    modport sink   (input valid, input sensor_bits, output ready);

endinterface

// File: rtl/lspe_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspe_out_if
// Result channel: filtered position and detection summary per transfer.
// ----------------------------------------------------------------------------
interface lspe_out_if import lspe_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [POS_W-1:0]    position;
    logic [COUNT_W-1:0]  line_count;
    logic                line_found;
    logic [SENSOR_W-1:0] detect_bits;

    modport source (output valid, output position, output line_count,
                    output line_found, output detect_bits, input ready);
    modport sink   (input valid, input position, input line_count,
                    input line_found, input detect_bits, output ready);

endinterface

// File: rtl/line_sensor_position_estimator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_sensor_position_estimator_core
// Scans a detector bitmap channel by channel for the longest runs, divides
// the index sum into a position, clamps it and smooths it with an EMA filter.
//
//   channel   dir  kind     payload
//   frame     in   vld/rdy  sensor_bits
//   result    out  vld/rdy  position, line_count, line_found, detect_bits
//   apb       in   APB      invert_logic, filter_alpha, pos_min, pos_max
//
// One frame at a time: a scan over CHANNELS + 1 positions, a setup state,
// the restoring divider at one quotient bit per cycle, then clamp and filter.
// A frame without a line skips the divider and the clamp.
// The divider's quotient width sets the bulk of the latency.
// frame.ready is high only in idle; a waiting result holds in the output
// register while the next frame is accepted and scanned.
// Reset is asynchronous, active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module line_sensor_position_estimator_core import lspe_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    lspe_in_if.sink               frame,
    lspe_out_if.source            result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W   = $clog2(CHANNELS + 1);
    localparam int CNT_W   = $clog2(CHANNELS + 1);
    localparam int SUM_MAX = CHANNELS * (CHANNELS - 1) / 2;
    localparam int SUM_W   = $clog2(SUM_MAX + 1);
    localparam int DIST_W  = $clog2(2 * CHANNELS + 1);
    localparam int NUM_W   = $clog2(SUM_MAX * POS_SPAN + 1);
    localparam int DEN_W   = $clog2((CHANNELS - 1) * CHANNELS + 1);
    localparam int ACC_W   = ALPHA_W + SMOOTH_W + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_PREP  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_CLAMP = 3'd4;
    localparam logic [2:0] S_FILT  = 3'd5;

    cfg_t cfg;

    logic [2:0]          state_reg,      state_next;
    logic [CHANNELS-1:0] bits_reg,       bits_next;
    logic [IDX_W-1:0]    idx_reg,        idx_next;
    logic [CNT_W-1:0]    run_reg,        run_next;
    logic [SUM_W-1:0]    run_sum_reg,    run_sum_next;
    logic [CNT_W-1:0]    total_reg,      total_next;
    logic [SUM_W-1:0]    all_sum_reg,    all_sum_next;
    logic [CNT_W-1:0]    long_len_reg,   long_len_next;
    logic [DIST_W-1:0]   near_gap_reg,   near_gap_next;
    logic [SUM_W-1:0]    close_sum_reg,  close_sum_next;
    logic                tie_reg,        tie_next;
    logic [POS_W-1:0]    pos_in_reg,     pos_in_next;
    logic [SMOOTH_W-1:0] smooth_reg,     smooth_next;
    logic [POS_W-1:0]    held_reg,       held_next;
    logic                res_valid_reg,  res_valid_next;
    logic [POS_W-1:0]    res_pos_reg,    res_pos_next;
    logic [COUNT_W-1:0]  res_count_reg,  res_count_next;
    logic                res_found_reg,  res_found_next;
    logic [SENSOR_W-1:0] res_detect_reg, res_detect_next;

    logic [SENSOR_W+CHANNELS-1:0] raw_ext;
    logic [CHANNELS-1:0]          raw_bits;
    logic [CHANNELS:0]            scan_bits;
    logic                         cur_bit;
    logic [DIST_W-1:0]            c2;
    logic [DIST_W-1:0]            a2;
    logic [DIST_W-1:0]            run_gap;
    logic [SUM_W-1:0]             sel_sum;
    logic [CNT_W-1:0]             sel_cnt;
    logic [NUM_W-1:0]             div_num;
    logic [DEN_W-1:0]             div_den;
    logic                         div_start;
    logic                         div_done;
    logic [NUM_W-1:0]             div_quo;
    logic [POS_W-1:0]             quo_pos;
    logic [POS_W-1:0]             lo_clamped;
    logic [ALPHA_W-1:0]           alpha_sat;
    logic [ALPHA_W-1:0]           weight_old;
    logic [ALPHA_W+POS_W-1:0]     prod_new;
    logic [ALPHA_W+SMOOTH_W-1:0]  prod_old;
    logic [ACC_W-1:0]             acc;
    logic [SMOOTH_W-1:0]          smooth_new;
    logic [SENSOR_W+CHANNELS-1:0] detect_ext;
    logic [COUNT_W+CNT_W-1:0]     count_ext;
    logic                         out_free;

    lspe_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    lspe_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign pready = 1'b1;

    assign raw_ext   = {{CHANNELS{1'b0}}, frame.sensor_bits};
    assign raw_bits  = raw_ext[CHANNELS-1:0] ^ {CHANNELS{cfg.invert_logic}};
    assign scan_bits = {1'b0, bits_reg};
    assign cur_bit   = scan_bits[idx_reg];

    assign c2      = (DIST_W'(idx_reg) << 1) - DIST_W'(run_reg) - DIST_W'(1);
    assign a2      = DIST_W'(CHANNELS - 1);
    assign run_gap = (c2 > a2) ? (c2 - a2) : (a2 - c2);

    assign sel_sum   = tie_reg ? all_sum_reg : close_sum_reg;
    assign sel_cnt   = tie_reg ? total_reg : long_len_reg;
    assign div_num   = NUM_W'(sel_sum) * NUM_W'(POS_SPAN);
    assign div_den   = DEN_W'(CHANNELS - 1) * DEN_W'(sel_cnt);
    assign div_start = (state_reg == S_PREP) && (total_reg != '0);

    assign quo_pos    = div_quo[POS_W-1:0];
    assign lo_clamped = (quo_pos < cfg.pos_min) ? cfg.pos_min : quo_pos;

    assign alpha_sat  = (cfg.filter_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.filter_alpha;
    assign weight_old = ALPHA_ONE - alpha_sat;
    assign prod_new   = alpha_sat * pos_in_reg;
    assign prod_old   = weight_old * smooth_reg;
    assign acc        = ACC_W'({prod_new, {FRAC_W{1'b0}}}) + ACC_W'(prod_old);
    assign smooth_new = acc[ALPHA_FRAC_W+SMOOTH_W-1:ALPHA_FRAC_W];

    assign detect_ext = {{SENSOR_W{1'b0}}, bits_reg};
    assign count_ext  = {{COUNT_W{1'b0}}, total_reg};
    assign out_free   = !res_valid_reg || result.ready;

    always_comb
    begin
        state_next      = state_reg;
        bits_next       = bits_reg;
        idx_next        = idx_reg;
        run_next        = run_reg;
        run_sum_next    = run_sum_reg;
        total_next      = total_reg;
        all_sum_next    = all_sum_reg;
        long_len_next   = long_len_reg;
        near_gap_next   = near_gap_reg;
        close_sum_next  = close_sum_reg;
        tie_next        = tie_reg;
        pos_in_next     = pos_in_reg;
        smooth_next     = smooth_reg;
        held_next       = held_reg;
        res_valid_next  = res_valid_reg && !result.ready;
        res_pos_next    = res_pos_reg;
        res_count_next  = res_count_reg;
        res_found_next  = res_found_reg;
        res_detect_next = res_detect_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (frame.valid)
                begin
                    bits_next     = raw_bits;
                    idx_next      = '0;
                    run_next      = '0;
                    run_sum_next  = '0;
                    total_next    = '0;
                    all_sum_next  = '0;
                    long_len_next = '0;
                    tie_next      = 1'b0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (cur_bit)
                begin
                    run_next     = run_reg + CNT_W'(1);
                    run_sum_next = run_sum_reg + SUM_W'(idx_reg);
                    total_next   = total_reg + CNT_W'(1);
                    all_sum_next = all_sum_reg + SUM_W'(idx_reg);
                end
                else
                begin
                    if (run_reg != '0)
                    begin
                        if (run_reg > long_len_reg)
                        begin
                            long_len_next  = run_reg;
                            near_gap_next  = run_gap;
                            close_sum_next = run_sum_reg;
                            tie_next       = 1'b0;
                        end
                        else if (run_reg == long_len_reg)
                        begin
                            if (run_gap < near_gap_reg)
                            begin
                                near_gap_next  = run_gap;
                                close_sum_next = run_sum_reg;
                                tie_next       = 1'b0;
                            end
                            else if (run_gap == near_gap_reg)
                            begin
                                tie_next = 1'b1;
                            end
                        end
                    end
                    run_next     = '0;
                    run_sum_next = '0;
                end
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == IDX_W'(CHANNELS))
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (total_reg == '0)
                begin
                    pos_in_next = held_reg;
                    state_next  = S_FILT;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_CLAMP;
                end
            end
            S_CLAMP:
            begin
                pos_in_next = (lo_clamped > cfg.pos_max) ? cfg.pos_max : lo_clamped;
                state_next  = S_FILT;
            end
            S_FILT:
            begin
                if (out_free)
                begin
                    smooth_next     = smooth_new;
                    res_valid_next  = 1'b1;
                    res_pos_next    = smooth_new[SMOOTH_W-1:FRAC_W];
                    res_count_next  = count_ext[COUNT_W-1:0];
                    res_found_next  = (total_reg != '0);
                    res_detect_next = detect_ext[SENSOR_W-1:0];
                    if (total_reg != '0)
                    begin
                        held_next = smooth_new[SMOOTH_W-1:FRAC_W];
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            smooth_reg    <= SMOOTH_RESET;
            held_reg      <= HELD_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            smooth_reg    <= smooth_next;
            held_reg      <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg       <= bits_next;
        idx_reg        <= idx_next;
        run_reg        <= run_next;
        run_sum_reg    <= run_sum_next;
        total_reg      <= total_next;
        all_sum_reg    <= all_sum_next;
        long_len_reg   <= long_len_next;
        near_gap_reg   <= near_gap_next;
        close_sum_reg  <= close_sum_next;
        tie_reg        <= tie_next;
        pos_in_reg     <= pos_in_next;
        res_pos_reg    <= res_pos_next;
        res_count_reg  <= res_count_next;
        res_found_reg  <= res_found_next;
        res_detect_reg <= res_detect_next;
    end

    assign frame.ready        = (state_reg == S_IDLE);
    assign result.valid       = res_valid_reg;
    assign result.position    = res_pos_reg;
    assign result.line_count  = res_count_reg;
    assign result.line_found  = res_found_reg;
    assign result.detect_bits = res_detect_reg;

endmodule

// File: rtl/lspe_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspe_cfg
// APB register file: inversion, filter weight and position limits.
// ----------------------------------------------------------------------------
module lspe_cfg import lspe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output cfg_t                  cfg
);

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[REG_IDX_W+1:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_INVERT:  cfg_next.invert_logic = pwdata[0];
                REG_ALPHA:   cfg_next.filter_alpha = pwdata[ALPHA_W-1:0];
                REG_POS_MIN: cfg_next.pos_min      = pwdata[POS_W-1:0];
                REG_POS_MAX: cfg_next.pos_max      = pwdata[POS_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.invert_logic <= 1'b0;
            cfg_reg.filter_alpha <= ALPHA_W'(128);
            cfg_reg.pos_min      <= '0;
            cfg_reg.pos_max      <= POS_W'(POS_SPAN);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_INVERT:  prdata = APB_DATA_W'(cfg_reg.invert_logic);
            REG_ALPHA:   prdata = APB_DATA_W'(cfg_reg.filter_alpha);
            REG_POS_MIN: prdata = APB_DATA_W'(cfg_reg.pos_min);
            REG_POS_MAX: prdata = APB_DATA_W'(cfg_reg.pos_max);
            default:     prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/lspe_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspe_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lspe_div import lspe_pkg::*;
#(
    parameter int NUM_W = 13,
    parameter int DEN_W = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int STEP_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_W - 1);

    logic              busy_reg;
    logic              busy_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [NUM_W-1:0]  quo_reg;
    logic [NUM_W-1:0]  quo_next;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  rem_next;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  den_next;
    logic [DEN_W:0]    rem_shift;
    logic [DEN_W:0]    rem_trial;
    logic              fits;

    assign rem_shift = {rem_reg, quo_reg[NUM_W-1]};
    assign rem_trial = rem_shift - {1'b0, den_reg};
    assign fits      = (rem_shift >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[NUM_W-2:0], fits};
            rem_next  = fits ? rem_trial[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_LAST)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            den_reg  <= den_next;
        end
    end

    assign done     = busy_reg && (step_reg == STEP_LAST);
    assign quotient = quo_reg;

endmodule

// File: rtl/lspe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspe_checker
// Port-level checks of the line sensor position estimator, bound to the top.
// ----------------------------------------------------------------------------
module lspe_checker import lspe_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEFAULT
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                frame_valid,
    input logic                frame_ready,
    input logic                result_valid,
    input logic                result_ready,
    input logic [POS_W-1:0]    position,
    input logic [COUNT_W-1:0]  line_count,
    input logic [SENSOR_W-1:0] detect_bits
);

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_ready |=> !frame_ready)
        else $error("frame ready right after a frame transfer");

    a_count_matches_bits: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (CHANNELS <= SENSOR_W) |-> line_count == $countones(detect_bits))
        else $error("line count disagrees with detect bits");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(position)
            && $stable(line_count) && $stable(detect_bits))
        else $error("stalled result changed");

endmodule

bind line_sensor_position_estimator_core lspe_checker #(.CHANNELS(CHANNELS)) u_lspe_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_valid  (frame.valid),
    .frame_ready  (frame.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .position     (result.position),
    .line_count   (result.line_count),
    .detect_bits  (result.detect_bits)
);

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the line sensor position estimator core. Drives
// detector frames over the frame channel and programs the registers over
// APB between phases. Every accepted frame is run through a cycle-free
// estimate of run search, division, clamp and EMA filter. Every result
// transfer is compared field by field with the oldest pending estimate.
// ----------------------------------------------------------------------------
module testbench;
    import lspe_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int NCH           = CHANNELS_DEFAULT;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 110;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 5000;
    localparam int MAX_PRINTS    = 40;

    typedef struct packed {
        logic [POS_W-1:0]    position;
        logic [COUNT_W-1:0]  line_count;
        logic                line_found;
        logic [SENSOR_W-1:0] detect_bits;
    } estimate_t;

    typedef struct packed {
        logic [SENSOR_W-1:0] bits;
        logic                given;
        estimate_t           want;
    } probe_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    lspe_in_if  frame_ch ();
    lspe_out_if result_ch ();

    line_sensor_position_estimator_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .frame   (frame_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    cfg_t                est_cfg;
    logic [SMOOTH_W-1:0] smooth_q;
    logic [POS_W-1:0]    held_pos;
    estimate_t           pending_estimates [$];

    int  mismatch_count = 0;
    int  quiet_cycles   = 0;
    int  send_idle_pct  = 0;
    int  recv_idle_pct  = 0;
    bit  hold_request   = 1'b0;

    probe_t probes [22] = '{
        '{8'h00, 1'b1, '{8'd80, 4'd0, 1'b0, 8'h00}},
        '{8'hFF, 1'b1, '{8'd80, 4'd8, 1'b1, 8'hFF}},
        '{8'h01, 1'b0, '0}, '{8'h80, 1'b0, '0}, '{8'h18, 1'b0, '0},
        '{8'h81, 1'b0, '0}, '{8'h24, 1'b0, '0}, '{8'h05, 1'b0, '0},
        '{8'h33, 1'b0, '0}, '{8'h0F, 1'b0, '0}, '{8'hF0, 1'b0, '0},
        '{8'h7E, 1'b0, '0}, '{8'hAA, 1'b0, '0}, '{8'h55, 1'b0, '0},
        '{8'h3C, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h66, 1'b0, '0},
        '{8'hC3, 1'b0, '0}, '{8'h99, 1'b0, '0}, '{8'h42, 1'b0, '0},
        '{8'h00, 1'b0, '0}, '{8'h3C, 1'b0, '0}
    };

    cfg_t phase_cfgs [8] = '{
        '{1'b0, 9'd128, 8'd0,   8'd160},
        '{1'b1, 9'd0,   8'd0,   8'd160},
        '{1'b0, 9'd256, 8'd20,  8'd140},
        '{1'b1, 9'd511, 8'd100, 8'd50},
        '{1'b0, 9'd1,   8'd0,   8'd0},
        '{1'b1, 9'd255, 8'd255, 8'd255},
        '{1'b0, 9'd257, 8'd0,   8'd255},
        '{1'b1, 9'd64,  8'd160, 8'd0}
    };

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < MAX_PRINTS)
            $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic estimate_t estimate_frame(input logic [SENSOR_W-1:0] raw);
        logic [SENSOR_W-1:0] det;
        logic [63:0]         mix;
        estimate_t           r;
        int total, run, long_len, n_best, n_close, near_gap, close_start;
        int i, s, c2, d, sum, cnt, pos, alpha;
        det = est_cfg.invert_logic ? ~raw : raw;
        total = $countones(det);
        long_len = 0;
        run = 0;
        for (i = 0; i <= NCH; i++)
        begin
            if (i < NCH && det[i])
                run++;
            else
            begin
                if (run > long_len)
                    long_len = run;
                run = 0;
            end
        end
        n_best = 0;
        n_close = 0;
        near_gap = 1 << 30;
        close_start = 0;
        run = 0;
        for (i = 0; i <= NCH; i++)
        begin
            if (i < NCH && det[i])
                run++;
            else
            begin
                if (long_len > 0 && run == long_len)
                begin
                    s = i - run;
                    c2 = 2 * s + run - 1;
                    d = (c2 > NCH - 1) ? c2 - (NCH - 1) : (NCH - 1) - c2;
                    n_best++;
                    if (d < near_gap)
                    begin
                        near_gap = d;
                        n_close = 1;
                        close_start = s;
                    end
                    else if (d == near_gap)
                        n_close++;
                end
                run = 0;
            end
        end
        if (total == 0)
            pos = int'(held_pos);
        else
        begin
            sum = 0;
            cnt = 0;
            if (n_best == 1 || n_close == 1)
            begin
                for (i = close_start; i < close_start + long_len; i++)
                begin
                    sum += i;
                    cnt++;
                end
            end
            else
            begin
                for (i = 0; i < NCH; i++)
                begin
                    if (det[i])
                    begin
                        sum += i;
                        cnt++;
                    end
                end
            end
            pos = (sum * POS_SPAN) / ((NCH - 1) * cnt);
            if (pos < int'(est_cfg.pos_min))
                pos = int'(est_cfg.pos_min);
            if (pos > int'(est_cfg.pos_max))
                pos = int'(est_cfg.pos_max);
        end
        alpha = (est_cfg.filter_alpha > ALPHA_ONE) ? 256 : int'(est_cfg.filter_alpha);
        mix = (64'(alpha) * (64'(pos) << FRAC_W) + 64'(256 - alpha) * 64'(smooth_q))
              >> ALPHA_FRAC_W;
        smooth_q = mix[SMOOTH_W-1:0];
        r.position = smooth_q[SMOOTH_W-1 -: POS_W];
        if (total > 0)
            held_pos = r.position;
        r.line_count = COUNT_W'(total);
        r.line_found = (total > 0);
        r.detect_bits = det;
        return r;
    endfunction

    function automatic logic [SENSOR_W-1:0] make_frame();
        logic [SENSOR_W-1:0] det;
        int kind, len, s1, s2;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2: det = SENSOR_W'($urandom);
            3, 4, 5:
            begin
                len = $urandom_range(1, NCH);
                s1 = $urandom_range(0, NCH - len);
                det = SENSOR_W'(((1 << len) - 1) << s1);
            end
            6, 7:
            begin
                len = $urandom_range(1, 3);
                s1 = $urandom_range(0, NCH - 1 - 2 * len);
                s2 = $urandom_range(s1 + len + 1, NCH - len);
                det = SENSOR_W'((((1 << len) - 1) << s1) | (((1 << len) - 1) << s2));
            end
            8: det = '0;
            default: det = '1;
        endcase
        return est_cfg.invert_logic ? ~det : det;
    endfunction

    task automatic push_frame(input logic [SENSOR_W-1:0] raw, input logic given,
                              input estimate_t want);
        estimate_t predicted;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            frame_ch.valid <= 1'b0;
            @(negedge clk);
        end
        frame_ch.valid <= 1'b1;
        frame_ch.sensor_bits <= raw;
        do
            @(posedge clk);
        while (!frame_ch.ready);
        predicted = estimate_frame(raw);
        pending_estimates.push_back(given ? want : predicted);
    endtask

    task automatic flush_pending();
        @(negedge clk);
        frame_ch.valid <= 1'b0;
        while (pending_estimates.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_xfer(input logic wr, input logic [REG_IDX_W-1:0] idx,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= APB_ADDR_W'({idx, 2'b00});
        pwdata <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_reg(input logic [REG_IDX_W-1:0] idx, input int field);
        logic [APB_DATA_W-1:0] mask, wdata, rdata;
        case (idx)
            REG_INVERT:
            begin
                mask = 32'h1;
                est_cfg.invert_logic = field[0];
            end
            REG_ALPHA:
            begin
                mask = 32'h1FF;
                est_cfg.filter_alpha = field[ALPHA_W-1:0];
            end
            REG_POS_MIN:
            begin
                mask = 32'hFF;
                est_cfg.pos_min = field[POS_W-1:0];
            end
            default:
            begin
                mask = 32'hFF;
                est_cfg.pos_max = field[POS_W-1:0];
            end
        endcase
        wdata = $urandom_range(0, 1) ? (APB_DATA_W'($urandom) & ~mask) : '0;
        wdata = wdata | (APB_DATA_W'(field) & mask);
        apb_xfer(1'b1, idx, wdata, rdata);
        apb_xfer(1'b0, idx, '0, rdata);
        if (rdata !== (APB_DATA_W'(field) & mask))
            report_mismatch($sformatf("readback reg %0d", idx), rdata, field & mask);
    endtask

    task automatic apply_config(input cfg_t c);
        program_reg(REG_INVERT, int'(c.invert_logic));
        program_reg(REG_ALPHA, int'(c.filter_alpha));
        program_reg(REG_POS_MIN, int'(c.pos_min));
        program_reg(REG_POS_MAX, int'(c.pos_max));
    endtask

    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                repeat (LONG_HOLD)
                begin
                    result_ch.ready <= 1'b0;
                    @(negedge clk);
                end
            end
            result_ch.ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        estimate_t want;
        if (result_ch.valid && result_ch.ready)
        begin
            if (pending_estimates.size() == 0)
                report_mismatch("result with no pending frame", int'(result_ch.position), -1);
            else
            begin
                want = pending_estimates.pop_front();
                if (result_ch.position !== want.position)
                    report_mismatch("position", int'(result_ch.position),
                                    int'(want.position));
                if (result_ch.line_count !== want.line_count)
                    report_mismatch("line_count", int'(result_ch.line_count),
                                    int'(want.line_count));
                if (result_ch.line_found !== want.line_found)
                    report_mismatch("line_found", int'(result_ch.line_found),
                                    int'(want.line_found));
                if (result_ch.detect_bits !== want.detect_bits)
                    report_mismatch("detect_bits", int'(result_ch.detect_bits),
                                    int'(want.detect_bits));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (frame_ch.valid && frame_ch.ready) ||
            (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("[%0t] no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        cfg_t c;
        rst_n = 1'b0;
        frame_ch.valid = 1'b0;
        frame_ch.sensor_bits = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        est_cfg = '{1'b0, 9'd128, 8'd0, 8'd160};
        smooth_q = SMOOTH_RESET;
        held_pos = HELD_RESET;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 11;
        recv_idle_pct = 71;
        foreach (probes[k])
            push_frame(probes[k].bits, probes[k].given, probes[k].want);

        for (int p = 0; p < PHASES; p++)
        begin
            flush_pending();
            if (p == 4)
            begin
                send_idle_pct = 71;
                recv_idle_pct = 11;
            end
            else if (p == 8)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p < 8)
                c = phase_cfgs[p];
            else
            begin
                c.invert_logic = 1'($urandom_range(0, 1));
                c.filter_alpha = ALPHA_W'(($urandom_range(0, 3) == 0) ?
                                          $urandom_range(257, 511) :
                                          $urandom_range(0, 256));
                if ($urandom_range(0, 3) == 0)
                begin
                    c.pos_min = POS_W'($urandom_range(0, 255));
                    c.pos_max = POS_W'($urandom_range(0, 255));
                end
                else
                begin
                    c.pos_min = POS_W'($urandom_range(0, 80));
                    c.pos_max = POS_W'($urandom_range(80, POS_SPAN));
                end
            end
            apply_config(c);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 9 && n == 30)
                    hold_request = 1'b1;
                push_frame(make_frame(), 1'b0, '0);
            end
        end

        flush_pending();
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
